/* hdl/lpht_pkg.sv */
`default_nettype none
package lpht_pkg;

  // table geometry
  localparam int TABLE_SIZE = 1024;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W      = 11;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  // field widths
  localparam int KIND_W   = 2;
  localparam int KEY_W    = 64;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // slot states
  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_TOMB  = 2'd1;
  localparam logic [1:0] SLOT_BUSY  = 2'd2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_STORE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  localparam logic [CNT_W-1:0] MAX_USED_RESET = 11'd716;

  typedef struct packed {
    logic [1:0]         state;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } slot_t;

endpackage
`default_nettype wire

/* hdl/linear_probe_hash_table_core.sv */
`default_nettype none
// Linear-probing key/value table of 1024 slots. A request (store, delete or
// lookup of a 64-bit key) is taken when start is high and busy is low, and
// exactly one result comes back on the result ports, marked by result_valid_o
// for a single cycle; the receiver cannot stall, so the result must be taken
// in that cycle. After reset the block sweeps all 1024 slots to empty, one
// per cycle, and holds busy high until the sweep is done. A request passes
// through hashing on one shared 64-bit add/xor unit (nine steps), then for
// each probed slot (1 to 1024 of them) a registered read of the slot memory
// and a check, and at last one update of the slot and the counters, after
// which the result strobe follows. Busy drops in the strobe cycle, so the
// next request can be accepted at the edge that ends it; no new request is
// taken while the last one is still in flight. The limit register
// max_used_q is written through its own valid/ready channel, which is
// always ready; write it only while busy is low.
module linear_probe_hash_table_core import lpht_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request channel
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [KIND_W-1:0]   kind_i,
  input  wire logic [KEY_W-1:0]    key_i,
  input  wire logic [VALUE_W-1:0]  value_i,
  // result channel
  output logic                     result_valid_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic                     found_o,
  output logic [VALUE_W-1:0]       value_out_o,
  output logic [CNT_W-1:0]         live_count_o,
  // configuration channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CNT_W-1:0]    cfg_data_i
);

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_APPLY = 3'd5;

  logic [2:0] state_q, state_d;

  // latched request
  logic [KIND_W-1:0]  kind_q;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] value_q;

  // probe bookkeeping
  logic [IDX_W-1:0]   idx_q, clr_q;
  logic [IDX_W-1:0]   cnt_q;
  logic               hit_q, has_empty_q;
  logic [VALUE_W-1:0] old_q;

  // counters and limit
  logic [CNT_W-1:0] busy_cnt_q, busy_cnt_d;
  logic [CNT_W-1:0] tomb_cnt_q, tomb_cnt_d;
  logic [CNT_W-1:0] max_used_q;
  logic             over_limit;

  // result registers
  logic               res_valid_q;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic               res_found_q;
  logic [VALUE_W-1:0] res_value_q;
  logic [CNT_W-1:0]   res_live_q;

  // hash unit
  logic             hash_start;
  logic             hash_done;
  logic [IDX_W-1:0] hash_index;

  // slot memory ports
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr;
  slot_t            mem_wdata, mem_rdata;

  logic accept;
  logic key_match;
  logic idx_wrap;

  assign accept     = start && !busy;
  assign hash_start = accept;
  assign key_match  = (mem_rdata.state == SLOT_BUSY) && (mem_rdata.key == key_q);
  assign idx_wrap   = (idx_q == LAST_IDX);

  // refusal limit covers busy and tombstone slots together
  assign over_limit = ({1'b0, busy_cnt_q} + {1'b0, tomb_cnt_q}) > {1'b0, max_used_q};

  lpht_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (key_i),
    .done_o  (hash_done),
    .index_o (hash_index)
  );

  lpht_slot_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST_IDX) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = ST_HASH;
      end
      ST_HASH: begin
        if (hash_done) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        // stop at an empty slot, at the key, or after one full pass
        if (mem_rdata.state == SLOT_EMPTY || key_match || cnt_q == LAST_IDX) begin
          state_d = ST_APPLY;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_APPLY: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign mem_re = (state_q == ST_READ);

  // clearing sweep, and slot update and counters at the end of the probe
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = '{state: SLOT_EMPTY, key: key_q, value: value_q};
    busy_cnt_d   = busy_cnt_q;
    tomb_cnt_d   = tomb_cnt_q;
    res_status_d = STATUS_OK;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
    end else if (state_q == ST_APPLY) begin
      case (kind_q)
        KIND_STORE: begin
          if (over_limit) begin
            res_status_d = STATUS_FULL;
          end else if (hit_q) begin
            // overwrite value in place
            mem_we    = 1'b1;
            mem_wdata = '{state: SLOT_BUSY, key: key_q, value: value_q};
          end else if (has_empty_q) begin
            mem_we     = 1'b1;
            mem_wdata  = '{state: SLOT_BUSY, key: key_q, value: value_q};
            busy_cnt_d = busy_cnt_q + 11'd1;
          end else begin
            res_status_d = STATUS_FULL;
          end
        end
        KIND_DELETE: begin
          if (hit_q) begin
            // leave a tombstone
            mem_we     = 1'b1;
            mem_wdata  = '{state: SLOT_TOMB, key: key_q, value: old_q};
            busy_cnt_d = busy_cnt_q - 11'd1;
            tomb_cnt_d = tomb_cnt_q + 11'd1;
          end else begin
            res_status_d = STATUS_NOT_FOUND;
          end
        end
        default: begin
          // lookup, and the unused kind code behaves the same
          if (!hit_q) res_status_d = STATUS_NOT_FOUND;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      busy_cnt_q  <= '0;
      tomb_cnt_q  <= '0;
      max_used_q  <= MAX_USED_RESET;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      busy_cnt_q  <= busy_cnt_d;
      tomb_cnt_q  <= tomb_cnt_d;
      res_valid_q <= (state_q == ST_APPLY);
      if (state_q == ST_CLEAR) clr_q <= clr_q + IDX_W'(1);
      if (cfg_valid_i) max_used_q <= cfg_data_i;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    if (state_q == ST_HASH && hash_done) begin
      idx_q       <= hash_index;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      has_empty_q <= 1'b0;
    end
    if (state_q == ST_CHECK) begin
      if (mem_rdata.state == SLOT_EMPTY) begin
        has_empty_q <= 1'b1;
      end else if (key_match) begin
        hit_q <= 1'b1;
        old_q <= mem_rdata.value;
      end else if (cnt_q != LAST_IDX) begin
        // linear step with wrap
        idx_q <= idx_wrap ? '0 : idx_q + IDX_W'(1);
        cnt_q <= cnt_q + IDX_W'(1);
      end
    end
    if (state_q == ST_APPLY) begin
      res_status_q <= res_status_d;
      res_found_q  <= hit_q;
      res_value_q  <= hit_q ? old_q : '0;
      res_live_q   <= busy_cnt_d;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign found_o        = res_found_q;
  assign value_out_o    = res_value_q;
  assign live_count_o   = res_live_q;

  // a result strobe only follows the update cycle
  a_result_after_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_APPLY))
    else $error("result strobe without update cycle");

  // an accepted transaction makes the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("not busy after accepted transaction");

  // only a store can be refused as full
  a_full_only_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == STATUS_FULL) |-> kind_q == KIND_STORE)
    else $error("full status on a non-store transaction");

  // busy and tombstone slots never exceed the table
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, busy_cnt_q} + {1'b0, tomb_cnt_q}) <= (CNT_W + 1)'(TABLE_SIZE))
    else $error("slot counters exceed table size");

endmodule
`default_nettype wire

/* hdl/lpht_hash.sv */
`default_nettype none
module lpht_hash import lpht_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [KEY_W-1:0] key_i,
  output logic                  done_o,
  output logic [IDX_W-1:0]      index_o
);

  // one add/xor step per cycle
  localparam logic [3:0] HS_NOT_ADD21 = 4'd0;
  localparam logic [3:0] HS_XOR24     = 4'd1;
  localparam logic [3:0] HS_ADD3      = 4'd2;
  localparam logic [3:0] HS_ADD8      = 4'd3;
  localparam logic [3:0] HS_XOR14     = 4'd4;
  localparam logic [3:0] HS_ADD2      = 4'd5;
  localparam logic [3:0] HS_ADD4      = 4'd6;
  localparam logic [3:0] HS_XOR28     = 4'd7;
  localparam logic [3:0] HS_ADD31     = 4'd8;

  logic [KEY_W-1:0] k_q, o_q, o_d;
  logic [KEY_W-1:0] op_a, op_b, op_y;
  logic             op_xor;
  logic [3:0]       step_q;
  logic             run_q, done_q;

  always_comb begin
    op_a   = k_q;
    op_b   = k_q << 21;
    op_xor = 1'b0;
    o_d    = o_q;
    case (step_q)
      HS_NOT_ADD21: begin
        op_a = ~k_q;
        op_b = k_q << 21;
      end
      HS_XOR24: begin
        op_b   = k_q >> 24;
        op_xor = 1'b1;
      end
      HS_ADD3: begin
        op_b = k_q << 3;
        o_d  = k_q;
      end
      HS_ADD8: begin
        op_b = o_q << 8;
      end
      HS_XOR14: begin
        op_b   = k_q >> 14;
        op_xor = 1'b1;
      end
      HS_ADD2: begin
        op_b = k_q << 2;
        o_d  = k_q;
      end
      HS_ADD4: begin
        op_b = o_q << 4;
      end
      HS_XOR28: begin
        op_b   = k_q >> 28;
        op_xor = 1'b1;
      end
      HS_ADD31: begin
        op_b = k_q << 31;
      end
      default: begin
        op_b = k_q;
      end
    endcase
  end

  // the shared 64-bit unit
  assign op_y = op_xor ? (op_a ^ op_b) : (op_a + op_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= HS_NOT_ADD21;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        step_q <= HS_NOT_ADD21;
        run_q  <= 1'b1;
      end else if (run_q) begin
        if (step_q == HS_ADD31) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      k_q <= key_i;
    end else if (run_q) begin
      k_q <= op_y;
      o_q <= o_d;
    end
  end

  assign done_o  = done_q;
  // table size is a power of two: the modulo is the low bits
  assign index_o = k_q[IDX_W-1:0];

endmodule
`default_nettype wire

/* hdl/lpht_slot_mem.sv */
`default_nettype none
module lpht_slot_mem import lpht_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] waddr_i,
  input  wire slot_t            wdata_i,
  input  wire logic             re_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output slot_t                 rdata_o
);

  slot_t mem_q [TABLE_SIZE];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* verif/testbench.sv */
module testbench;
  import lpht_pkg::*;

  // kind three has no operation of its own and behaves as a lookup
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam int POOL_SIZE    = 48;
  localparam int PHASE_ITEMS  = 150;
  // worst request: a probe over every slot in a full pass
  localparam int WORST_LAT    = 12 + 2 * TABLE_SIZE;
  localparam int DRAIN_CYCLES = WORST_LAT + 16;
  // quiet stretch covers the clearing sweep, a full-pass probe and the drain
  localparam int STALL_LIMIT  = 4 * (TABLE_SIZE + WORST_LAT + DRAIN_CYCLES);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [VALUE_W-1:0]  value_out;
    logic [CNT_W-1:0]    live_count;
  } table_result_t;

  // dut ports
  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [KIND_W-1:0]   kind_i;
  logic [KEY_W-1:0]    key_i;
  logic [VALUE_W-1:0]  value_i;
  logic                result_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic                found_o;
  logic [VALUE_W-1:0]  value_out_o;
  logic [CNT_W-1:0]    live_count_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CNT_W-1:0]    cfg_data_i;

  // shadow copy of the table, kept in step with every accepted request
  logic [1:0]          tbl_state [TABLE_SIZE];
  logic [KEY_W-1:0]    tbl_key   [TABLE_SIZE];
  logic [VALUE_W-1:0]  tbl_value [TABLE_SIZE];
  int                  tbl_busy;
  int                  tbl_tomb;
  int                  tbl_limit;

  // results still owed by the dut, oldest first
  table_result_t       expected_results [$];
  logic [KEY_W-1:0]    key_pool [POOL_SIZE];
  int                  mismatches;
  bit                  idle_on;

  linear_probe_hash_table_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .key_i          (key_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .found_o        (found_o),
    .value_out_o    (value_out_o),
    .live_count_o   (live_count_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // 64-bit shift/add/xor mix, reduced to a home slot
  function automatic logic [IDX_W-1:0] home_slot(input logic [KEY_W-1:0] key);
    logic [63:0] k;
    k = ~key + (key << 21);
    k = k ^ (k >> 24);
    k = k + (k << 3) + (k << 8);
    k = k ^ (k >> 14);
    k = k + (k << 2) + (k << 4);
    k = k ^ (k >> 28);
    k = k + (k << 31);
    return IDX_W'(k % 64'(TABLE_SIZE));
  endfunction

  // probe the shadow table, apply the request and return its result
  function automatic table_result_t apply_request(input logic [KIND_W-1:0] kind,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [VALUE_W-1:0] value);
    logic [IDX_W-1:0] idx;
    logic             hit;
    logic             has_empty;
    table_result_t    res;
    idx       = home_slot(key);
    hit       = 1'b0;
    has_empty = 1'b0;
    // linear probe with wrap: tombstones are stepped over, one pass at most
    for (int n = 0; n < TABLE_SIZE && !hit && !has_empty; n++) begin
      if (tbl_state[idx] == SLOT_EMPTY) begin
        has_empty = 1'b1;
      end else if (tbl_state[idx] == SLOT_BUSY && tbl_key[idx] == key) begin
        hit = 1'b1;
      end else begin
        idx = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
      end
    end
    res.status    = STATUS_OK;
    res.found     = hit;
    res.value_out = hit ? tbl_value[idx] : '0;
    case (kind)
      KIND_STORE: begin
        // over the limit nothing changes, even for a key already present
        if (tbl_busy + tbl_tomb > tbl_limit) begin
          res.status = STATUS_FULL;
        end else if (hit) begin
          tbl_value[idx] = value;
        end else if (has_empty) begin
          tbl_state[idx] = SLOT_BUSY;
          tbl_key[idx]   = key;
          tbl_value[idx] = value;
          tbl_busy++;
        end else begin
          res.status = STATUS_FULL;
        end
      end
      KIND_DELETE: begin
        if (hit) begin
          tbl_state[idx] = SLOT_TOMB;
          tbl_busy--;
          tbl_tomb++;
        end else begin
          res.status = STATUS_NOT_FOUND;
        end
      end
      default: begin
        if (!hit) res.status = STATUS_NOT_FOUND;
      end
    endcase
    res.live_count = CNT_W'(tbl_busy);
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // mostly keys from the pool so that hits, overwrites and deletes happen
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return rand_key();
  endfunction

  // one request transaction; the prediction is made at the accepting edge
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic [KEY_W-1:0] key,
                              input logic [VALUE_W-1:0] value);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      // let the gap fall either inside the request or after it
      if ($urandom_range(0, 1)) begin
        @(posedge clk_i);
        while (busy) @(posedge clk_i);
      end
      repeat (gap) @(negedge clk_i);
    end
    start   <= 1'b1;
    kind_i  <= kind;
    key_i   <= key;
    value_i <= value;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_results.push_back(apply_request(kind, key, value));
  endtask

  task automatic send_mixed_request();
    int                roll;
    logic [KIND_W-1:0] kind;
    roll = $urandom_range(0, 99);
    if (roll < 40)      kind = KIND_STORE;
    else if (roll < 60) kind = KIND_DELETE;
    else if (roll < 95) kind = KIND_LOOKUP;
    else                kind = KIND_SPARE;
    send_request(kind, pick_key(), $urandom);
  endtask

  // limit register write, only once the table has gone quiet
  task automatic write_slot_limit(input logic [CNT_W-1:0] limit);
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_results.size() != 0 || busy) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= limit;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tbl_limit = int'(limit);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // reset limit in effect before any write
  task automatic test_reset_limit();
    logic [KEY_W-1:0] k;
    k = rand_key();
    send_request(KIND_STORE, k, $urandom);
    send_request(KIND_LOOKUP, k, '0);
  endtask

  // smallest limit: refusals, also for a key already present
  task automatic test_limit_floor();
    write_slot_limit(CNT_W'(1));
    send_request(KIND_STORE, '0, '0);
    send_request(KIND_STORE, '1, '1);
    send_request(KIND_STORE, rand_key(), $urandom);
    send_request(KIND_STORE, '0, 32'h0000_1234);
    send_request(KIND_LOOKUP, '0, '1);
    send_request(KIND_SPARE, '1, '0);
    send_request(KIND_DELETE, '1, '0);
    send_request(KIND_DELETE, '1, '0);
    send_request(KIND_LOOKUP, '1, '0);
    send_request(KIND_LOOKUP, rand_key(), '0);
  endtask

  // largest limit: fresh store, overwrites, extreme values, delete to a tombstone
  task automatic test_limit_ceiling();
    write_slot_limit(CNT_W'(TABLE_SIZE));
    send_request(KIND_STORE, '1, '0);
    send_request(KIND_STORE, '0, '1);
    send_request(KIND_LOOKUP, '0, '0);
    send_request(KIND_STORE, '0, 32'h5555_5555);
    send_request(KIND_STORE, '1, 32'haaaa_aaaa);
    send_request(KIND_SPARE, '1, '0);
    send_request(KIND_DELETE, '0, '0);
    send_request(KIND_DELETE, rand_key(), '1);
  endtask

  // random traffic at moderate load over several limit settings
  task automatic test_random_mix();
    logic [CNT_W-1:0] limits [5];
    foreach (key_pool[i]) key_pool[i] = rand_key();
    limits[0] = MAX_USED_RESET;
    limits[1] = CNT_W'(1);
    limits[2] = CNT_W'($urandom_range(2, TABLE_SIZE));
    limits[3] = CNT_W'(TABLE_SIZE - 1);
    limits[4] = CNT_W'($urandom_range(1, TABLE_SIZE));
    idle_on = 1'b1;
    foreach (limits[p]) begin
      write_slot_limit(limits[p]);
      repeat (PHASE_ITEMS) send_mixed_request();
    end
  endtask

  // fresh stores until no empty slot is left
  task automatic test_fill_to_capacity();
    idle_on = 1'b0;
    write_slot_limit(CNT_W'(TABLE_SIZE));
    while (tbl_busy + tbl_tomb < TABLE_SIZE) send_request(KIND_STORE, rand_key(), $urandom);
  endtask

  // table without an empty slot: full-pass misses, then limit refusals
  task automatic test_full_table();
    send_request(KIND_STORE, rand_key(), $urandom);
    send_request(KIND_LOOKUP, rand_key(), $urandom);
    send_request(KIND_DELETE, rand_key(), $urandom);
    repeat (24) send_mixed_request();
    write_slot_limit(CNT_W'(TABLE_SIZE - 1));
    repeat (8) send_request(KIND_STORE, pick_key(), $urandom);
  endtask

  // compare every result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    table_result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d value %h",
                 $time, status_o, value_out_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, status_o);
          mismatches++;
        end
        if (found_o !== want.found) begin
          $display("%0t: found mismatch, expected %0d, actual %0d",
                   $time, want.found, found_o);
          mismatches++;
        end
        if (value_out_o !== want.value_out) begin
          $display("%0t: value_out mismatch, expected %h, actual %h",
                   $time, want.value_out, value_out_o);
          mismatches++;
        end
        if (live_count_o !== want.live_count) begin
          $display("%0t: live_count mismatch, expected %0d, actual %0d",
                   $time, want.live_count, live_count_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction of any kind
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    kind_i      = KIND_STORE;
    key_i       = '0;
    value_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    mismatches  = 0;
    idle_on     = 1'b1;
    foreach (tbl_state[i]) begin
      tbl_state[i] = SLOT_EMPTY;
      tbl_key[i]   = '0;
      tbl_value[i] = '0;
    end
    tbl_busy  = 0;
    tbl_tomb  = 0;
    tbl_limit = int'(MAX_USED_RESET);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_limit();
    test_limit_floor();
    test_limit_ceiling();
    test_random_mix();
    test_fill_to_capacity();
    test_full_table();

    // drain: wait for the last result, then a worst-case latency more
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/lpht_pkg.sv
hdl/lpht_hash.sv
hdl/lpht_slot_mem.sv
hdl/linear_probe_hash_table_core.sv
verif/testbench.sv
